// ===== src/pli_pkg.sv =====
// Shared widths, codes and types for the piecewise linear interpolator.
package pli_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int T_W    = 24;
    localparam int H_W    = 32;
    localparam int MODE_W = 2;
    localparam int STAT_W = 3;

    // |dh| * (t - t0) magnitude, and the add/sub unit one bit wider for the sign
    localparam int PROD_W = H_W + T_W;
    localparam int AU_W   = PROD_W + 1;
    localparam int STEP_W = $clog2(H_W + 1);

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_QUERY  = 2'd1;
    localparam mode_t MODE_CLEAR  = 2'd2;

    localparam status_t STAT_INTERP  = 3'd0;
    localparam status_t STAT_BELOW   = 3'd1;
    localparam status_t STAT_ABOVE   = 3'd2;
    localparam status_t STAT_EMPTY   = 3'd3;
    localparam status_t STAT_NOSEG   = 3'd4;
    localparam status_t STAT_STORED  = 3'd5;
    localparam status_t STAT_FULL    = 3'd6;
    localparam status_t STAT_CLEARED = 3'd7;

endpackage

// ===== src/piecewise_linear_interpolator.sv =====
// Top level: breakpoint table, segment search and shared add/sub sequencer.
//
// Piecewise linear interpolator over a table of up to TABLE_DEPTH breakpoints.
// Input stream (s_*): one request per handshake. s_tuser carries the mode
// (append, query, clear; code 3 acts as a query), s_tdata carries the
// temperature (unsigned 16.8) and the heat (signed 24.8, used by append).
// Output stream (m_*): exactly one result per request, in order. m_tdata is
// the heat (signed 24.8, zero when nothing to report), m_tuser the status.
// Append, clear and empty-table query give their result the cycle after
// acceptance. Other queries check the first and then the last entry for a
// clamp, then scan for the first enclosing segment, up to 15 scan steps. An
// interpolated query then uses one 57-bit add/sub unit for a 24-step
// shift-add multiply, a 32-step restoring divide and the final signed add
// with saturation. The table memory gives one entry per cycle in the scan.
// One request is in flight at a time; s_tready is high only while the
// sequencer is idle and the output register is empty or being drained.
// A stalled receiver holds m_tvalid and the result until m_tready.
// Reset clears the entry count and the sequencer; table contents persist
// but are never read beyond the count.
module piecewise_linear_interpolator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pli_pkg::T_W+pli_pkg::H_W-1:0]  s_tdata,  // temperature, heat
    input  pli_pkg::mode_t                        s_tuser,  // mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pli_pkg::H_W-1:0]               m_tdata,  // heat_out
    output pli_pkg::status_t                      m_tuser   // status
);
    import pli_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_CHK_FIRST = 7'b0000010,
        ST_CHK_LAST  = 7'b0000100,
        ST_SCAN      = 7'b0001000,
        ST_MUL       = 7'b0010000,
        ST_DIV       = 7'b0100000,
        ST_ADD       = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [H_W-1:0]       out_heat_reg, out_heat_next;
    status_t              out_stat_reg, out_stat_next;

    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [T_W-1:0]       t_q_reg, t_q_next;
    logic [T_W-1:0]       prev_t_reg, prev_t_next;
    logic [H_W-1:0]       prev_h_reg, prev_h_next;
    logic [T_W-1:0]       up_reg, up_next;
    logic [T_W-1:0]       down_reg, down_next;
    logic [H_W-1:0]       mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;

    // Table memory, registered read port
    logic [T_W-1:0]       temps_mem [TABLE_DEPTH];
    logic [H_W-1:0]       heats_mem [TABLE_DEPTH];
    logic [T_W-1:0]       rd_t_reg;
    logic [H_W-1:0]       rd_h_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;

    logic [T_W-1:0]       in_temp;
    logic [H_W-1:0]       in_heat;
    logic                 in_fire;
    logic [CNT_W-1:0]     count_m1;
    logic [IDX_W-1:0]     last_idx;

    // Shared add/sub unit
    logic [AU_W-1:0]      au_a, au_b, au_res;
    logic                 au_sub;

    // Segment setup
    logic [H_W:0]         dh;
    logic [H_W:0]         dh_abs;
    logic                 in_seg;
    logic [T_W-1:0]       rem_next;
    logic                 qbit;

    assign in_temp  = s_tdata[T_W-1:0];
    assign in_heat  = s_tdata[T_W+H_W-1:T_W];
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[IDX_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_heat_reg;
    assign m_tuser  = out_stat_reg;

    assign au_res = au_a + (au_sub ? ~au_b : au_b) + AU_W'(au_sub);

    assign dh     = {rd_h_reg[H_W-1], rd_h_reg} - {prev_h_reg[H_W-1], prev_h_reg};
    assign dh_abs = dh[H_W] ? (~dh + (H_W+1)'(1)) : dh;
    assign in_seg = (t_q_reg >= prev_t_reg) && (t_q_reg < rd_t_reg);

    // Restoring divide step: keep the trial difference when it did not borrow
    assign qbit     = !au_res[AU_W-1];
    assign rem_next = qbit ? au_res[T_W-1:0] : acc_reg[PROD_W-2:H_W-1];

    always_comb
    begin
        case (state_reg)
            ST_IDLE:     rd_addr = '0;
            ST_CHK_FIRST: rd_addr = last_idx;
            ST_CHK_LAST: rd_addr = IDX_W'(1);
            ST_SCAN:     rd_addr = idx_reg + IDX_W'(1);
            default:     rd_addr = '0;
        endcase
    end

    always_comb
    begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
        case (state_reg)
            ST_MUL:
            begin
                // MSB-first shift-add of |dh| * up
                au_a = {1'b0, acc_reg[PROD_W-2:0], 1'b0};
                au_b = up_reg[T_W-1] ? AU_W'(mag_reg) : '0;
            end
            ST_DIV:
            begin
                au_a   = AU_W'({acc_reg[PROD_W-1:H_W], acc_reg[H_W-1]});
                au_b   = AU_W'(down_reg);
                au_sub = 1'b1;
            end
            ST_ADD:
            begin
                au_a   = {{(AU_W-H_W){prev_h_reg[H_W-1]}}, prev_h_reg};
                au_b   = AU_W'(acc_reg[H_W-1:0]);
                au_sub = neg_reg;
            end
            default:
            begin
                au_a   = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_heat_next  = out_heat_reg;
        out_stat_next  = out_stat_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        t_q_next       = t_q_reg;
        prev_t_next    = prev_t_reg;
        prev_h_next    = prev_h_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        wr_en          = 1'b0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    t_q_next = in_temp;
                    case (s_tuser)
                        MODE_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            out_heat_next  = '0;
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                wr_en         = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                out_stat_next = STAT_STORED;
                            end
                            else
                            begin
                                out_stat_next = STAT_FULL;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                            out_heat_next  = '0;
                            out_stat_next  = STAT_CLEARED;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_heat_next  = '0;
                                out_stat_next  = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_CHK_FIRST;
                            end
                        end
                    endcase
                end
            end
            ST_CHK_FIRST:
            begin
                if (t_q_reg < rd_t_reg)
                begin
                    out_valid_next = 1'b1;
                    out_heat_next  = rd_h_reg;
                    out_stat_next  = STAT_BELOW;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    prev_t_next = rd_t_reg;
                    prev_h_next = rd_h_reg;
                    state_next  = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST:
            begin
                if (t_q_reg >= rd_t_reg)
                begin
                    out_valid_next = 1'b1;
                    out_heat_next  = rd_h_reg;
                    out_stat_next  = STAT_ABOVE;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    idx_next   = IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (in_seg)
                begin
                    up_next    = t_q_reg - prev_t_reg;
                    down_next  = rd_t_reg - prev_t_reg;
                    mag_next   = dh_abs[H_W-1:0];
                    neg_next   = dh[H_W];
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
                else if (idx_reg == last_idx)
                begin
                    out_valid_next = 1'b1;
                    out_heat_next  = '0;
                    out_stat_next  = STAT_NOSEG;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    prev_t_next = rd_t_reg;
                    prev_h_next = rd_h_reg;
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end
            ST_MUL:
            begin
                acc_next  = au_res[PROD_W-1:0];
                up_next   = {up_reg[T_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(T_W - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                acc_next  = {rem_next, acc_reg[H_W-2:0], qbit};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(H_W - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                out_valid_next = 1'b1;
                out_stat_next  = STAT_INTERP;
                state_next     = ST_IDLE;
                // Saturate when bits above the int32 sign are not a sign extension
                if (au_res[AU_W-1:H_W-1] == '0 || au_res[AU_W-1:H_W-1] == '1)
                begin
                    out_heat_next = au_res[H_W-1:0];
                end
                else if (au_res[AU_W-1])
                begin
                    out_heat_next = {1'b1, {(H_W-1){1'b0}}};
                end
                else
                begin
                    out_heat_next = {1'b0, {(H_W-1){1'b1}}};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_heat_reg <= out_heat_next;
        out_stat_reg <= out_stat_next;
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        t_q_reg      <= t_q_next;
        prev_t_reg   <= prev_t_next;
        prev_h_reg   <= prev_h_next;
        up_reg       <= up_next;
        down_reg     <= down_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            temps_mem[count_reg[IDX_W-1:0]] <= in_temp;
            heats_mem[count_reg[IDX_W-1:0]] <= in_heat;
        end
        rd_t_reg <= temps_mem[rd_addr];
        rd_h_reg <= heats_mem[rd_addr];
    end

endmodule

// ===== src/pli_checker.sv =====
// Port-level checker for the piecewise linear interpolator, with its bind.
module pli_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [pli_pkg::T_W+pli_pkg::H_W-1:0]  s_tdata,
    input pli_pkg::mode_t                        s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [pli_pkg::H_W-1:0]               m_tdata,
    input pli_pkg::status_t                      m_tuser
);
    import pli_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No new request while a result is stuck at the output
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

    // Clear answers on the next cycle
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_CLEAR |=>
            m_tvalid && m_tuser == STAT_CLEARED && m_tdata == '0)
        else $error("clear result missing");

    // Append answers on the next cycle, stored or full
    a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == MODE_APPEND |=>
            m_tvalid && (m_tuser == STAT_STORED || m_tuser == STAT_FULL))
        else $error("append result missing");

    // Results without a heat report zero
    a_zero_heat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_EMPTY || m_tuser == STAT_NOSEG ||
            m_tuser == STAT_STORED || m_tuser == STAT_FULL ||
            m_tuser == STAT_CLEARED) |-> m_tdata == '0)
        else $error("nonzero heat on a status without heat");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);

// ===== sim/heat_curve_checker.sv =====
// Result checker for the interpolator: predicts each request's heat and status, compares in order.
module heat_curve_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [pli_pkg::T_W+pli_pkg::H_W-1:0]  s_tdata,  // temperature, heat
    input  pli_pkg::mode_t                        s_tuser,  // mode
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [pli_pkg::H_W-1:0]               m_tdata,  // heat_out
    input  pli_pkg::status_t                      m_tuser,  // status
    output int                                    fail_count,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    typedef struct packed {
        logic [H_W-1:0] heat;
        status_t        status;
    } heat_result_t;

    localparam longint HEAT_MAX = 64'sd2147483647;
    localparam longint HEAT_MIN = -64'sd2147483648;

    logic [T_W-1:0]        curve_temps [TABLE_DEPTH];
    logic signed [H_W-1:0] curve_heats [TABLE_DEPTH];
    int                    curve_count = 0;
    heat_result_t          expected_results [$];

    // Applies one request to the local copy of the table and returns its result.
    function automatic heat_result_t predict_heat(input mode_t mode,
                                                  input logic [T_W-1:0] temp,
                                                  input logic signed [H_W-1:0] heat);
        heat_result_t r;
        int           seg;
        longint       h0;
        longint       rise;
        longint       run;
        longint       sum;
        r.heat = '0;
        seg    = -1;
        if (mode == MODE_APPEND)
        begin
            if (curve_count < TABLE_DEPTH)
            begin
                curve_temps[curve_count] = temp;
                curve_heats[curve_count] = heat;
                curve_count++;
                r.status = STAT_STORED;
            end
            else
                r.status = STAT_FULL;
        end
        else if (mode == MODE_CLEAR)
        begin
            curve_count = 0;
            r.status    = STAT_CLEARED;
        end
        else if (curve_count == 0)
            r.status = STAT_EMPTY;
        else if (temp < curve_temps[0])
        begin
            r.heat   = curve_heats[0];
            r.status = STAT_BELOW;
        end
        else if (temp >= curve_temps[curve_count - 1])
        begin
            r.heat   = curve_heats[curve_count - 1];
            r.status = STAT_ABOVE;
        end
        else
        begin
            // first enclosing segment; the table need not be in order
            for (int j = 0; j + 1 < curve_count; j++)
                if (seg < 0 && temp >= curve_temps[j] && temp < curve_temps[j + 1])
                    seg = j;
            if (seg < 0)
                r.status = STAT_NOSEG;
            else
            begin
                h0   = curve_heats[seg];
                rise = temp - curve_temps[seg];
                run  = curve_temps[seg + 1] - curve_temps[seg];
                // signed 64-bit divide truncates toward zero
                sum  = h0 + ((longint'(curve_heats[seg + 1]) - h0) * rise) / run;
                if (sum > HEAT_MAX)
                    r.heat = 32'h7FFF_FFFF;
                else if (sum < HEAT_MIN)
                    r.heat = 32'h8000_0000;
                else
                    r.heat = sum[H_W-1:0];
                r.status = STAT_INTERP;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        heat_result_t want;
        if (rst_n)
        begin
            // result side first: a result always belongs to an older request
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, heat_out %h status %0d",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.heat)
                    begin
                        $display("%0t: heat_out expected %h got %h", $time, want.heat, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        predict_heat(s_tuser, s_tdata[T_W-1:0],
                                                     s_tdata[T_W+H_W-1:T_W]));
            pending = expected_results.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the piecewise linear interpolator: stimulus, result stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 750;
    localparam int CALM_ITEMS   = 100;    // final requests run with no idling on either side
    localparam int DRAIN_CYCLES = 100;    // beyond the slowest query
    localparam int DRAIN_LIMIT  = 10000;

    // Spare mode code; the block decodes it as a query.
    localparam mode_t MODE_SPARE = 2'd3;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [T_W+H_W-1:0] s_tdata  = '0;           // temperature, heat
    mode_t              s_tuser  = MODE_APPEND;  // mode
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [H_W-1:0]     m_tdata;                 // heat_out
    status_t            m_tuser;                 // status

    int fail_count;
    int pending;

    bit calm       = 1'b0;   // set for the tail of the run: no gaps, no stalls
    int stall_left = 0;
    int sent       = 0;

    // Temperatures of the valid table entries, kept only to aim queries at segments.
    logic [T_W-1:0] live_temps [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    piecewise_linear_interpolator dut (.*);

    heat_curve_checker checker_i (.*);

    // Receiver: random stall bursts, no new ones once the run is calm.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 6);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Presents one request, possibly after a short gap, and returns at the edge that
    // accepts it. Valid stays high on return so back-to-back requests need no toggle.
    task automatic send_request(input mode_t mode, input logic [T_W-1:0] temp,
                                input logic [H_W-1:0] heat);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {heat, temp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        if (mode == MODE_APPEND && live_temps.size() < TABLE_DEPTH)
            live_temps.insert(live_temps.size(), temp);
        else if (mode == MODE_CLEAR)
            live_temps.delete();
    endtask

    initial
    begin
        logic [T_W-1:0] temp;
        logic [T_W-1:0] lo;
        logic [T_W-1:0] hi;
        logic [T_W-1:0] points [$];
        int             target;
        int             kind;
        int             n_points;
        int             span;
        int             base;
        int             j;
        int             drain_wait;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // Queries right after reset hit the empty table, also through the spare code.
        send_request(MODE_QUERY, 24'h000000, 32'h0000_0000);
        send_request(MODE_SPARE, 24'hFFFFFF, 32'hFFFF_FFFF);

        // Fill the table: smallest heat first, largest heat next, top temperature last.
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == 0)
                send_request(MODE_APPEND, 24'h000001, 32'h8000_0000);
            else if (i == 1)
                send_request(MODE_APPEND, 24'h000100, 32'h7FFF_FFFF);
            else if (i == TABLE_DEPTH - 1)
                send_request(MODE_APPEND, 24'hFFFFFF, 32'h0000_0000);
            else
            begin
                temp = T_W'(i * 24'h111111);
                send_request(MODE_APPEND, temp, $urandom);
            end
        end
        // One more append is dropped: table full.
        send_request(MODE_APPEND, 24'h123456, 32'h5A5A_5A5A);

        send_request(MODE_QUERY, 24'h000000, 32'h0);   // below the first breakpoint
        send_request(MODE_QUERY, 24'h000080, 32'h0);   // full-scale rise, widest product
        send_request(MODE_QUERY, 24'h0000FF, 32'h0);   // one step short of a breakpoint
        send_request(MODE_QUERY, 24'h777777, 32'h0);   // exactly on an inner breakpoint
        send_request(MODE_QUERY, 24'hFFFFFE, 32'h0);   // last segment
        send_request(MODE_SPARE, 24'hFFFFFF, 32'h0);   // at the last breakpoint
        send_request(MODE_CLEAR, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_request(MODE_QUERY, 24'h800000, 32'h0);   // empty again after clear

        // Hold off until every result is back, once for certain.
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);

        // ---- random part ----
        // Mostly: clear, build a curve, then aim queries at its segments and ends.
        // Out-of-order tables still always leave an enclosing segment for a query
        // between the end temperatures, so they show up as ordinary interpolations.
        target = sent + RANDOM_ITEMS;
        while (sent < target)
        begin
            calm = (sent >= target - CALM_ITEMS);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise: every field random, spare mode included
                repeat ($urandom_range(1, 4))
                begin
                    temp = T_W'($urandom);
                    send_request(mode_t'($urandom_range(0, 3)), temp, $urandom);
                end
            end
            else
            begin
                // kind 1 keeps appending onto whatever is left; kind 2 builds out of order
                if (kind != 1)
                    send_request(MODE_CLEAR, T_W'($urandom), $urandom);
                n_points = $urandom_range(1, TABLE_DEPTH + 2);
                span     = ($urandom_range(0, 2) == 0) ? 24'hFFFFFF : $urandom_range(8, 4096);
                base     = $urandom_range(0, 24'hFFFFFF - span);
                points.delete();
                repeat (n_points)
                    points.insert(points.size(), T_W'(base + $urandom_range(0, span)));
                if (kind != 2)
                    points.sort();
                foreach (points[i])
                    send_request(MODE_APPEND, points[i], $urandom);

                repeat ($urandom_range(2, 12))
                begin
                    temp = T_W'($urandom);
                    if (live_temps.size() > 0)
                    begin
                        lo = live_temps[0];
                        hi = live_temps[live_temps.size() - 1];
                        case ($urandom_range(0, 5))
                            0:
                                temp = live_temps[$urandom_range(0, live_temps.size() - 1)];
                            1, 2:
                            begin
                                if (live_temps.size() > 1)
                                begin
                                    j  = $urandom_range(0, live_temps.size() - 2);
                                    lo = live_temps[j];
                                    hi = live_temps[j + 1];
                                end
                                temp = (hi > lo) ? lo + T_W'($urandom_range(0, hi - lo - 1))
                                                 : T_W'($urandom_range(hi, lo));
                            end
                            3:
                                temp = (lo > 0) ? T_W'($urandom_range(0, lo - 1)) : lo;
                            4:
                                temp = T_W'($urandom_range(hi, 24'hFFFFFF));
                            default:
                                ;   // keep the fully random temperature
                        endcase
                    end
                    send_request(($urandom_range(0, 7) == 0) ? MODE_SPARE : MODE_QUERY,
                                 temp, $urandom);
                end

                if (!calm && $urandom_range(0, 9) == 0)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                    while (pending != 0)
                        @(negedge clk);
                    @(posedge clk);
                end
            end
        end

        // ---- drain ----
        s_tvalid   <= 1'b0;
        drain_wait = 0;
        @(negedge clk);
        while (pending != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
        begin
            if (pending != 0)
                $display("%0t: %0d results never arrived", $time, pending);
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 800 requests).
    initial
    begin
        #10ms;
        $display("testbench failed");
        $finish;
    end

endmodule
